FILE: rtl/gpm_pkg.sv
// ============================================================================
// Glob pattern matcher package
// Shared constants, input function codes and the item record that moves
// from one matcher cell to the next.
// ============================================================================
package gpm_pkg;

    // Default pattern storage depth in bytes.
    localparam int unsigned PATTERN_LENGTH_DEFAULT = 32;

    // Input function codes.
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_SUBJECT = 2'd1;
    localparam logic [1:0] FUNC_EVAL    = 2'd2;

    // Pattern metacharacters.
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ESC   = 8'h5C;

    // Kind of item that travels down the cell chain.
    typedef enum logic [1:0] {
        TOK_NONE = 2'd0,
        TOK_LOAD = 2'd1,
        TOK_SUBJ = 2'd2,
        TOK_EVAL = 2'd3
    } tok_kind_t;

    // Item record handed from a cell to its right-hand neighbor.
    // The flag bits describe work pending at the receiving cell.
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;        // subject or pattern byte
        logic       first;       // load clears the stored pattern
        logic       pending;     // load byte not yet written
        logic       prev_valid;  // sending cell holds a pattern byte
        logic       star_carry;  // star closure reaches this cell
        logic       act;         // this position becomes active
        logic       esc;         // previous cell is an active backslash
        logic       elem;        // this cell starts a class element
        logic       after;       // previous cell was a missed class element
        logic [7:0] after_lo;    // byte of that missed element
        logic       hi;          // this cell is the upper end of a range
        logic [7:0] hi_lo;       // lower end of that range
        logic       seek;        // class matched, looking for its close
        logic       result;      // evaluate: end position is active
    } token_t;

endpackage

FILE: rtl/gpm_cell.sv
// ============================================================================
// Glob pattern matcher cell
// Holds one pattern byte, its valid bit and one active-position bit. Applies
// the item coming from the left neighbor and registers the item for the
// right neighbor.
// ============================================================================
module gpm_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            start_cell,
    input  gpm_pkg::token_t tok_in,
    output gpm_pkg::token_t tok_out
);
    import gpm_pkg::*;

    logic       active_reg;
    logic       active_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] pattern_reg;
    token_t     tok_reg;
    token_t     tok_next;

    logic       cur_active;
    logic       byte_eq;
    logic       is_star;
    logic       is_quest;
    logic       is_lbr;
    logic       is_esc;
    logic       is_dash;
    logic       is_rbr;
    logic       is_lit;
    logic       is_end;
    logic       elem_eff;
    logic       elem_ok;
    logic       in_range;
    logic       hi_ok;
    logic       valid_eff;
    logic       write_en;

    // Decode of the stored byte; only a valid cell counts as pattern.
    assign byte_eq  = (pattern_reg == tok_in.data);
    assign is_star  = valid_reg && (pattern_reg == CH_STAR);
    assign is_quest = valid_reg && (pattern_reg == CH_QUEST);
    assign is_lbr   = valid_reg && (pattern_reg == CH_LBR);
    assign is_esc   = valid_reg && (pattern_reg == CH_ESC);
    assign is_dash  = valid_reg && (pattern_reg == CH_DASH);
    assign is_rbr   = valid_reg && (pattern_reg == CH_RBR);
    assign is_lit   = valid_reg && !(pattern_reg == CH_STAR) && !(pattern_reg == CH_QUEST)
                      && !(pattern_reg == CH_LBR) && !(pattern_reg == CH_ESC) && byte_eq;

    // The end position is the first cell without a pattern byte.
    assign is_end = !valid_reg && tok_in.prev_valid;

    // Class element handling: a missed element followed by a dash opens a range.
    assign elem_eff = tok_in.elem || (tok_in.after && !is_dash);
    assign elem_ok  = elem_eff && valid_reg && !is_rbr;
    assign in_range = ((tok_in.hi_lo <= tok_in.data) && (pattern_reg >= tok_in.data))
                      || ((tok_in.hi_lo >= tok_in.data) && (pattern_reg <= tok_in.data));
    assign hi_ok    = tok_in.hi && valid_reg && in_range;

    assign cur_active = active_reg || tok_in.star_carry;

    // Next item and next cell state.
    always_comb begin
        tok_next            = '0;
        tok_next.kind       = tok_in.kind;
        tok_next.data       = tok_in.data;
        tok_next.first      = tok_in.first;
        tok_next.prev_valid = valid_reg;
        tok_next.result     = tok_in.result;
        active_next         = active_reg;
        valid_next          = valid_reg;
        valid_eff           = valid_reg;
        write_en            = 1'b0;
        unique case (tok_in.kind)
            TOK_SUBJ: begin
                tok_next.star_carry = cur_active && is_star;
                tok_next.act        = (cur_active && (is_quest || is_lit))
                                      || (tok_in.esc && valid_reg && byte_eq)
                                      || (tok_in.seek && is_rbr)
                                      || (hi_ok && is_rbr);
                tok_next.esc        = cur_active && is_esc;
                tok_next.elem       = (cur_active && is_lbr)
                                      || (tok_in.hi && valid_reg && !in_range);
                tok_next.seek       = (elem_ok && byte_eq)
                                      || (tok_in.seek && valid_reg && !is_rbr)
                                      || (hi_ok && !is_rbr);
                tok_next.after      = elem_ok && !byte_eq;
                tok_next.after_lo   = pattern_reg;
                tok_next.hi         = tok_in.after && is_dash;
                tok_next.hi_lo      = tok_in.after_lo;
                active_next         = (cur_active && is_star) || tok_in.act
                                      || (tok_in.seek && !valid_reg);
            end
            TOK_EVAL: begin
                tok_next.star_carry = cur_active && is_star;
                tok_next.result     = tok_in.result || (is_end && cur_active);
                active_next         = start_cell;
            end
            TOK_LOAD: begin
                valid_eff           = valid_reg && !tok_in.first;
                write_en            = tok_in.pending && !valid_eff;
                valid_next          = valid_eff || write_en;
                tok_next.pending    = tok_in.pending && valid_eff;
                tok_next.prev_valid = valid_next;
                active_next         = start_cell;
            end
            default: begin
            end
        endcase
    end

    // Control state and the handoff register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= start_cell;
            valid_reg  <= 1'b0;
            tok_reg    <= '0;
        end else if (advance) begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            tok_reg    <= tok_next;
        end
    end

    // Pattern byte storage.
    always_ff @(posedge aclk) begin
        if (advance && write_en) begin
            pattern_reg <= tok_in.data;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/glob_pattern_matcher_unit.sv
// ============================================================================
// Glob pattern matcher unit
// Stores a glob pattern byte by byte and matches a subject stream against it.
// ============================================================================
// The block accepts one item per clock cycle while the input is not stalled,
// pattern bytes, subject bytes and evaluate commands alike, and returns the
// result of an evaluate command through the output register. Each item walks a
// chain of PATTERN_LENGTH + 1 cells, one per pattern position plus the end
// position, one cell per cycle while the chain advances, and then enters the
// output register. The input stalls only while an evaluate result has reached
// the end of the chain and the previous result is still waiting at the output.
// Zero subject bytes and the unused function code take an input slot but
// change nothing.
module glob_pattern_matcher_unit #(
    parameter int unsigned PATTERN_LENGTH = gpm_pkg::PATTERN_LENGTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_data_byte,
    input  logic       s_first,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic       m_pattern_overflow
);
    import gpm_pkg::*;

    localparam int unsigned NUM_CELLS = PATTERN_LENGTH + 1;

    token_t in_tok;
    token_t cell_in  [NUM_CELLS];
    token_t cell_out [NUM_CELLS];
    token_t tail_tok;
    token_t store_tail_tok;

    logic   advance;
    logic   ovf_reg;
    logic   m_valid_reg;
    logic   m_matched_reg;
    logic   m_overflow_reg;

    assign tail_tok       = cell_out[NUM_CELLS-1];
    assign store_tail_tok = cell_out[NUM_CELLS-2];

    // The chain moves unless an evaluate result has nowhere to go.
    assign advance = !((tail_tok.kind == TOK_EVAL) && m_valid_reg && !m_ready);
    assign s_ready = advance;

    // Turn an accepted input item into a chain item.
    always_comb begin
        in_tok            = '0;
        in_tok.data       = s_data_byte;
        in_tok.first      = s_first;
        in_tok.prev_valid = 1'b1;
        if (s_valid && s_ready) begin
            unique case (s_func)
                FUNC_LOAD: begin
                    in_tok.kind    = TOK_LOAD;
                    in_tok.pending = (s_data_byte != 8'd0);
                end
                FUNC_SUBJECT: begin
                    if (s_data_byte != 8'd0) begin
                        in_tok.kind = TOK_SUBJ;
                    end
                end
                FUNC_EVAL: begin
                    in_tok.kind = TOK_EVAL;
                end
                default: begin
                end
            endcase
        end
    end

    // Neighbor links; the end-only cell never takes a pattern byte.
    always_comb begin
        cell_in[0] = in_tok;
        for (int k = 1; k < NUM_CELLS; k++) begin
            cell_in[k] = cell_out[k-1];
        end
        cell_in[NUM_CELLS-1].pending = 1'b0;
    end

    // Row of matcher cells.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        gpm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .start_cell (k == 0),
            .tok_in     (cell_in[k]),
            .tok_out    (cell_out[k])
        );
    end

    // Overflow: a load byte that found no free cell is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg <= 1'b0;
        end else if (advance && (store_tail_tok.kind == TOK_LOAD)) begin
            ovf_reg <= (ovf_reg && !store_tail_tok.first) || store_tail_tok.pending;
        end
    end

    // Output register for evaluate results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && (tail_tok.kind == TOK_EVAL)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && (tail_tok.kind == TOK_EVAL)) begin
            m_matched_reg  <= tail_tok.result && !ovf_reg;
            m_overflow_reg <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_overflow_reg;

`ifndef SYNTHESIS
    // An overflowed pattern never reports a match.
    a_no_match_on_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_matched_reg && m_overflow_reg))
        else $error("match reported with overflowed pattern");

    // The input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("input stalled without a waiting result");

    // An evaluate item leaving the chain always produces a result.
    a_eval_delivered: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (tail_tok.kind == TOK_EVAL)) |=> m_valid_reg)
        else $error("evaluate item lost at chain end");

    // A result appears only from an evaluate item.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(advance && (tail_tok.kind == TOK_EVAL)))
        else $error("result without evaluate item");
`endif

endmodule
